// ===== hw/rtl/cap_pkg.sv =====
package cap_pkg;

  localparam int DEF_FRAME_WIDTH  = 16;
  localparam int DEF_FRAME_HEIGHT = 16;

  localparam int         NIBBLE_BITS = 4;
  localparam logic [3:0] CHANNEL_MAX = 4'd15;

  localparam logic REQ_PLOT = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } cap_state_t;

  typedef struct packed {
    logic in_frame;
    logic swap_xy;
    logic rotate_ccw;
  } cap_map_ctl_t;

  function automatic logic [3:0] sat_add4(input logic [3:0] a, input logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[4] ? CHANNEL_MAX : s[3:0];
  endfunction

endpackage

// ===== hw/rtl/clipped_additive_pixel_plotter.sv =====
// latency: result strobe in the cycle after the accepting edge, one cycle long
// one item at a time: busy is high in ST_EXEC, so no new item is taken during
//   its frame memory read-modify-write (read at accept, write in the next cycle)
// reset: rotate_ccw clears to 0; the frame memory is then cleared one pixel per
//   cycle, all FRAME_WIDTH*FRAME_HEIGHT pixels, with busy high
// the receiver cannot stall: out_valid is a one-cycle strobe
module clipped_additive_pixel_plotter import cap_pkg::*; #(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [3:0]         in_red_in,
  input  logic [3:0]         in_green_in,
  input  logic               in_additive,
  input  logic               in_swap_xy,
  output logic               out_valid,
  output logic [7:0]         out_pixel_value,
  output logic               out_in_frame
);

  localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cap_state_t        state_r, state_nxt;
  logic              rotate_ccw_r;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data_r;

  cap_map_ctl_t      map_ctl;
  logic [ADDR_W-1:0] map_addr;
  logic              accept;

  logic              req_read_r;
  logic              additive_r;
  logic [3:0]        red_r;
  logic [3:0]        green_r;
  logic              frame_r;
  logic [ADDR_W-1:0] addr_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [3:0]        new_red;
  logic [3:0]        new_green;
  logic [7:0]        new_pix;
  logic              clr_done;

  assign map_ctl.swap_xy    = in_swap_xy;
  assign map_ctl.rotate_ccw = rotate_ccw_r;

  cap_map #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_map (
    .pos_x      (in_pos_x),
    .pos_y      (in_pos_y),
    .swap_xy    (map_ctl.swap_xy),
    .rotate_ccw (map_ctl.rotate_ccw),
    .in_frame   (map_ctl.in_frame),
    .addr       (map_addr)
  );

  assign accept   = start && !busy;
  assign clr_done = (clr_cnt_r == ADDR_W'(DEPTH - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (start)    state_nxt = ST_EXEC;
      ST_EXEC:                state_nxt = ST_IDLE;
      default:                state_nxt = ST_CLEAR;
    endcase
  end

  // pixel update
  always_comb begin
    new_red   = additive_r ? sat_add4(rd_data_r[3:0], red_r) : red_r;
    new_green = additive_r ? sat_add4(rd_data_r[7:4], green_r) : green_r;
    new_pix   = (req_read_r == REQ_READ) ? rd_data_r : {new_green, new_red};
  end

  // outputs
  always_comb begin
    busy        = 1'b1;
    out_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_r;
    mem_wdata   = new_pix;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = 8'd0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_EXEC: begin
        out_valid = 1'b1;
        mem_we    = frame_r && (req_read_r == REQ_PLOT);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign out_pixel_value = frame_r ? new_pix : 8'd0;
  assign out_in_frame    = frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      rotate_ccw_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_wr_en) begin
        rotate_ccw_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_read_r <= in_req_type;
      additive_r <= in_additive;
      red_r      <= in_red_in;
      green_r    <= in_green_in;
      frame_r    <= map_ctl.in_frame;
      addr_r     <= map_addr;
    end
  end

  // frame memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[map_addr];
  end

endmodule

// ===== hw/rtl/cap_map.sv =====
module cap_map import cap_pkg::*; #(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
  parameter int ADDR_W       = 8
) (
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic               swap_xy,
  input  logic               rotate_ccw,
  output logic               in_frame,
  output logic [ADDR_W-1:0]  addr
);

  logic signed [15:0] sx;
  logic signed [15:0] sy;
  logic [15:0]        ux;
  logic [15:0]        uy;
  logic [31:0]        lin_full;
  logic [31:0]        rot_full;

  always_comb begin
    sx = swap_xy ? pos_y : pos_x;
    sy = swap_xy ? pos_x : pos_y;
    ux = unsigned'(sx);
    uy = unsigned'(sy);
  end

  // coordinates are nonnegative once the sign bit is clear
  assign in_frame = !sx[15] && !sy[15]
                 && (ux < 16'(FRAME_WIDTH)) && (uy < 16'(FRAME_HEIGHT));

  assign lin_full = {16'd0, uy} * 32'(FRAME_WIDTH) + {16'd0, ux};
  assign rot_full = {16'd0, ux} * 32'(FRAME_HEIGHT) + 32'(FRAME_HEIGHT - 1) - {16'd0, uy};

  assign addr = rotate_ccw ? rot_full[ADDR_W-1:0] : lin_full[ADDR_W-1:0];

endmodule
